/* rtl/dipf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipf_pkg
// Shared widths, register indexes and reset values for the deepest interior
// pixel finder.
// ----------------------------------------------------------------------------
package dipf_pkg;

    localparam int DIM_W      = 8;   // window width / height and coordinates
    localparam int DEPTH_W    = 9;   // stored city-block distance
    localparam int ORG_W      = 12;  // window origin
    localparam int CNT_W      = 15;  // set pixel count and threshold
    localparam int SEED_W     = 13;  // reported seed position
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEED   = 3'd4;

    localparam logic [DIM_W-1:0] RST_WIN_WIDTH  = 8'd128;
    localparam logic [DIM_W-1:0] RST_WIN_HEIGHT = 8'd128;
    localparam logic [CNT_W-1:0] RST_MIN_SEED   = 15'd2;

endpackage

/* rtl/deepest_interior_pixel_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deepest_interior_pixel_finder
// Loads a binary window mask, runs a forward and a backward city-block
// distance pass over it and reports the first deepest pixel or a not-found result.
// ----------------------------------------------------------------------------
// Loading: one mask beat per cycle into the distance store when o_in_ready.
// After the last beat of a window both passes run before the result (two store
// accesses per pixel in each of the two passes, one shared min unit); a
// not-found result is ready the cycle after the last beat. No new mask beats
// are taken while the passes run.
// Reset (synchronous, active low) clears control and registers; the store is
// not cleared, every entry is written during loading before it is read.

module deepest_interior_pixel_finder #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [dipf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dipf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // mask input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_pixel_valid,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [dipf_pkg::SEED_W-1:0]         o_seed_x,
    output logic [dipf_pkg::SEED_W-1:0]         o_seed_y,
    output logic [dipf_pkg::DEPTH_W-1:0]        o_depth
);
    import dipf_pkg::*;

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FWD_RD,
        S_FWD_WR,
        S_BWD_RD,
        S_BWD_WR,
        S_FINISH
    } t_state;

    // configuration registers
    logic [DIM_W-1:0]   r_win_width;
    logic [DIM_W-1:0]   r_win_height;
    logic [ORG_W-1:0]   r_origin_x;
    logic [ORG_W-1:0]   r_origin_y;
    logic [CNT_W-1:0]   r_min_seed;

    t_state             r_state;
    logic [DIM_W-1:0]   r_col;
    logic [DIM_W-1:0]   r_row;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_last_addr;
    logic [CNT_W-1:0]   r_count;
    logic [DEPTH_W-1:0] r_prev;
    logic [DEPTH_W-1:0] r_best_depth;
    logic [DIM_W-1:0]   r_best_x;
    logic [DIM_W-1:0]   r_best_y;

    logic               r_out_valid;
    logic               r_found;
    logic [SEED_W-1:0]  r_seed_x;
    logic [SEED_W-1:0]  r_seed_y;
    logic [DEPTH_W-1:0] r_depth;

    // distance store, one write and two read ports
    logic [DEPTH_W-1:0] r_mem [MEM_DEPTH];
    logic [DEPTH_W-1:0] r_rd_self;
    logic [DEPTH_W-1:0] r_rd_vert;
    logic [AW-1:0]      rd_addr_vert;
    logic               mem_we;
    logic [DEPTH_W-1:0] mem_wdata;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic               col_end;
    logic               row_end;
    logic               in_beat;
    logic               geom_wr;
    logic [CNT_W-1:0]   count_next;
    logic [DEPTH_W:0]   cand_horz;
    logic [DEPTH_W:0]   cand_vert;
    logic [DEPTH_W-1:0] new_dist;
    logic               fwd;

    function automatic logic [DEPTH_W-1:0] min3(input logic [DEPTH_W-1:0] d,
                                                input logic [DEPTH_W:0]   a,
                                                input logic [DEPTH_W:0]   b);
        logic [DEPTH_W:0] m;
        m = {1'b0, d};
        if (a < m) m = a;
        if (b < m) m = b;
        return m[DEPTH_W-1:0];
    endfunction

    // clamp the window geometry to the store
    always_comb begin
        if (r_win_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (int'(r_win_width) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_win_width;
        end
        if (r_win_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (int'(r_win_height) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_win_height;
        end
    end

    assign fwd     = (r_state == S_FWD_RD) || (r_state == S_FWD_WR);
    assign col_end = fwd || (r_state == S_LOAD) ? (r_col == w_eff - DIM_W'(1))
                                                : (r_col == '0);
    assign row_end = fwd || (r_state == S_LOAD) ? (r_row == h_eff - DIM_W'(1))
                                                : (r_row == '0);

    assign o_in_ready = (r_state == S_LOAD) && !(col_end && row_end && r_out_valid);
    assign in_beat    = i_in_valid && o_in_ready;
    assign geom_wr    = i_cfg_wr_en && ((i_cfg_index == REG_WIN_WIDTH)
                                     || (i_cfg_index == REG_WIN_HEIGHT));
    assign count_next = r_count + CNT_W'(i_pixel_valid);

    // shared min unit: the horizontal neighbour comes from the previous result,
    // the vertical one from the second read port
    always_comb begin
        if (fwd) begin
            cand_horz = (r_col != '0) ? {1'b0, r_prev} + 1'b1 : (DEPTH_W+1)'(1);
            cand_vert = (r_row != '0) ? {1'b0, r_rd_vert} + 1'b1 : (DEPTH_W+1)'(1);
        end else begin
            cand_horz = (r_col != w_eff - DIM_W'(1)) ? {1'b0, r_prev} + 1'b1
                                                     : (DEPTH_W+1)'(1);
            cand_vert = (r_row != h_eff - DIM_W'(1)) ? {1'b0, r_rd_vert} + 1'b1
                                                     : (DEPTH_W+1)'(1);
        end
        new_dist = (r_rd_self == '0) ? '0 : min3(r_rd_self, cand_horz, cand_vert);
    end

    assign rd_addr_vert = fwd ? r_addr - AW'(w_eff) : r_addr + AW'(w_eff);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = new_dist;
        if (r_state == S_LOAD && in_beat) begin
            mem_we    = 1'b1;
            mem_wdata = i_pixel_valid ? DEPTH_W'(w_eff) + DEPTH_W'(h_eff) : '0;
        end else if (r_state == S_FWD_WR || r_state == S_BWD_WR) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rd_self <= r_mem[r_addr];
        r_rd_vert <= r_mem[rd_addr_vert];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_width  <= RST_WIN_WIDTH;
            r_win_height <= RST_WIN_HEIGHT;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_min_seed   <= RST_MIN_SEED;
            r_state      <= S_LOAD;
            r_col        <= '0;
            r_row        <= '0;
            r_addr       <= '0;
            r_last_addr  <= '0;
            r_count      <= '0;
            r_prev       <= '0;
            r_best_depth <= '0;
            r_best_x     <= '0;
            r_best_y     <= '0;
            r_out_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_seed_x     <= '0;
            r_seed_y     <= '0;
            r_depth      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_WIN_WIDTH:  r_win_width  <= i_cfg_data[DIM_W-1:0];
                    REG_WIN_HEIGHT: r_win_height <= i_cfg_data[DIM_W-1:0];
                    REG_ORIGIN_X:   r_origin_x   <= i_cfg_data[ORG_W-1:0];
                    REG_ORIGIN_Y:   r_origin_y   <= i_cfg_data[ORG_W-1:0];
                    REG_MIN_SEED:   r_min_seed   <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (geom_wr) begin
                        // new geometry restarts the window
                        r_col   <= '0;
                        r_row   <= '0;
                        r_addr  <= '0;
                        r_count <= '0;
                    end else if (in_beat) begin
                        r_count <= count_next;
                        r_addr  <= r_addr + 1'b1;
                        r_col   <= r_col + 1'b1;
                        if (col_end) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                            if (row_end) begin
                                r_row       <= '0;
                                r_count     <= '0;
                                r_addr      <= '0;
                                r_last_addr <= r_addr;
                                if (count_next < r_min_seed) begin
                                    r_out_valid <= 1'b1;
                                    r_found     <= 1'b0;
                                    r_seed_x    <= '0;
                                    r_seed_y    <= '0;
                                    r_depth     <= '0;
                                end else begin
                                    r_state <= S_FWD_RD;
                                end
                            end
                        end
                    end
                end
                S_FWD_RD: r_state <= S_FWD_WR;
                S_FWD_WR: begin
                    r_prev  <= new_dist;
                    r_addr  <= r_addr + 1'b1;
                    r_col   <= r_col + 1'b1;
                    r_state <= S_FWD_RD;
                    if (col_end) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                        if (row_end) begin
                            // backward pass starts at the last pixel
                            r_col        <= w_eff - DIM_W'(1);
                            r_row        <= h_eff - DIM_W'(1);
                            r_addr       <= r_last_addr;
                            r_best_depth <= '0;
                            r_state      <= S_BWD_RD;
                        end
                    end
                end
                S_BWD_RD: r_state <= S_BWD_WR;
                S_BWD_WR: begin
                    r_prev  <= new_dist;
                    r_addr  <= r_addr - 1'b1;
                    r_col   <= r_col - 1'b1;
                    r_state <= S_BWD_RD;
                    // ties move the best towards the start of the raster
                    if (new_dist >= r_best_depth) begin
                        r_best_depth <= new_dist;
                        r_best_x     <= r_col;
                        r_best_y     <= r_row;
                    end
                    if (col_end) begin
                        r_col <= w_eff - DIM_W'(1);
                        r_row <= r_row - 1'b1;
                        if (row_end) begin
                            r_col   <= '0;
                            r_row   <= '0;
                            r_addr  <= '0;
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_found     <= 1'b1;
                        r_seed_x    <= SEED_W'(r_origin_x) + SEED_W'(r_best_x);
                        r_seed_y    <= SEED_W'(r_origin_y) + SEED_W'(r_best_y);
                        r_depth     <= r_best_depth;
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_seed_x    = r_seed_x;
    assign o_seed_y    = r_seed_y;
    assign o_depth     = r_depth;

endmodule

/* tb/tb_deepest_interior_pixel_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deepest_interior_pixel_finder
// Streams window masks into the finder and checks each reported seed against
// a local distance-transform predictor. A short directed set covers the corner
// cases. Random windows, mostly small with a few at full width or height,
// follow, with random idling on both channels and long result hold-offs.
// ----------------------------------------------------------------------------
module tb_deepest_interior_pixel_finder;
    import dipf_pkg::*;

    localparam int MAX_W          = 128;
    localparam int MAX_H          = 128;
    localparam int CLK_HALF       = 10;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int QUIET_CYCLES   = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int TARGET_BEATS   = 800;
    localparam int MIN_SETTINGS   = 5;
    localparam int HOLD_CYCLES    = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_pixel_valid;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_found;
    logic [SEED_W-1:0]     o_seed_x;
    logic [SEED_W-1:0]     o_seed_y;
    logic [DEPTH_W-1:0]    o_depth;

    typedef struct packed {
        logic                found;
        logic [SEED_W-1:0]   seed_x;
        logic [SEED_W-1:0]   seed_y;
        logic [DEPTH_W-1:0]  depth;
    } t_seed;

    class seed_scoreboard;
        logic [DIM_W-1:0]   win_w_reg = RST_WIN_WIDTH;
        logic [DIM_W-1:0]   win_h_reg = RST_WIN_HEIGHT;
        logic [ORG_W-1:0]   org_x     = '0;
        logic [ORG_W-1:0]   org_y     = '0;
        logic [CNT_W-1:0]   min_seeds = RST_MIN_SEED;
        int                 load_col  = 0;
        int                 load_row  = 0;
        logic [CNT_W-1:0]   set_count = '0;
        logic [DEPTH_W-1:0] dist_store [MAX_W*MAX_H];
        t_seed              pending_seeds [$];
        int                 n_beats     = 0;
        int                 n_found     = 0;
        int                 n_not_found = 0;
        int                 n_errors    = 0;

        function int clamp_dim(logic [DIM_W-1:0] v, int lim);
            if (v == 0) return 1;
            if (v > lim) return lim;
            return v;
        endfunction

        function int window_pixels();
            return clamp_dim(win_w_reg, MAX_W) * clamp_dim(win_h_reg, MAX_H);
        endfunction

        function void restart_window();
            load_col  = 0;
            load_row  = 0;
            set_count = '0;
        endfunction

        function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIN_WIDTH: begin
                    win_w_reg = data[DIM_W-1:0];
                    restart_window();
                end
                REG_WIN_HEIGHT: begin
                    win_h_reg = data[DIM_W-1:0];
                    restart_window();
                end
                REG_ORIGIN_X: org_x     = data[ORG_W-1:0];
                REG_ORIGIN_Y: org_y     = data[ORG_W-1:0];
                REG_MIN_SEED: min_seeds = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // one mask beat; the last beat of a window queues its seed
        function void note_mask_bit(logic bit_in);
            int    w, h, k, d, a, b, best_pos;
            int    best;
            t_seed res;
            w = clamp_dim(win_w_reg, MAX_W);
            h = clamp_dim(win_h_reg, MAX_H);
            n_beats++;
            if (load_col >= w || load_row >= h) restart_window();
            k = load_row * w + load_col;
            if (bit_in) begin
                dist_store[k] = DEPTH_W'(w + h);
                set_count++;
            end else begin
                dist_store[k] = '0;
            end
            if (load_col + 1 < w) begin
                load_col++;
                return;
            end
            load_col = 0;
            if (load_row + 1 < h) begin
                load_row++;
                return;
            end
            res = '0;
            if (set_count < min_seeds) begin
                restart_window();
                n_not_found++;
                pending_seeds = {pending_seeds, res};
                return;
            end
            restart_window();
            // forward pass: left and upper neighbours, outside counts as background
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++) begin
                    k = y * w + x;
                    d = dist_store[k];
                    if (d != 0) begin
                        a = (x > 0) ? int'(dist_store[k-1]) + 1 : 1;
                        b = (y > 0) ? int'(dist_store[k-w]) + 1 : 1;
                        if (a < d) d = a;
                        if (b < d) d = b;
                        dist_store[k] = DEPTH_W'(d);
                    end
                end
            end
            // backward pass: right and lower neighbours
            for (int y = h - 1; y >= 0; y--) begin
                for (int x = w - 1; x >= 0; x--) begin
                    k = y * w + x;
                    d = dist_store[k];
                    if (d != 0) begin
                        a = (x + 1 < w) ? int'(dist_store[k+1]) + 1 : 1;
                        b = (y + 1 < h) ? int'(dist_store[k+w]) + 1 : 1;
                        if (a < d) d = a;
                        if (b < d) d = b;
                        dist_store[k] = DEPTH_W'(d);
                    end
                end
            end
            best     = dist_store[0];
            best_pos = 0;
            for (int i = 1; i < w * h; i++) begin
                if (dist_store[i] > best) begin
                    best     = dist_store[i];
                    best_pos = i;
                end
            end
            res.found  = 1'b1;
            res.seed_x = SEED_W'(int'(org_x) + best_pos % w);
            res.seed_y = SEED_W'(int'(org_y) + best_pos / w);
            res.depth  = DEPTH_W'(best);
            n_found++;
            pending_seeds = {pending_seeds, res};
        endfunction

        function void note_error(string msg);
            n_errors++;
            if (n_errors <= 10) $display("error at %0t ns: %s", $time, msg);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) note_error($sformatf("%s expected %0d got %0d", name, want, got));
        endfunction

        function void check_seed(logic found, logic [SEED_W-1:0] sx, logic [SEED_W-1:0] sy,
                                 logic [DEPTH_W-1:0] dep);
            t_seed want;
            if (pending_seeds.size() == 0) begin
                note_error($sformatf("unexpected result beat: found %0d x %0d y %0d depth %0d",
                                     found, sx, sy, dep));
                return;
            end
            want = pending_seeds.pop_front();
            check_field("found", want.found, found);
            check_field("seed_x", want.seed_x, sx);
            check_field("seed_y", want.seed_y, sy);
            check_field("depth", want.depth, dep);
        endfunction
    endclass

    seed_scoreboard sb = new();
    int             cycle_count = 0;
    int             result_hold = 0;
    bit             tx_burst    = 1'b0;
    int             n_settings  = 0;
    int             n_aborted   = 0;

    deepest_interior_pixel_finder #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_valid (i_pixel_valid),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_seed_x      (o_seed_x),
        .o_seed_y      (o_seed_y),
        .o_depth       (o_depth)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d seeds outstanding",
                 cycle_count, sb.pending_seeds.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sometimes fill the bits above the register width with noise
    function automatic logic [CFG_DATA_W-1:0] with_junk(int value, int bits);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(value);
        if (bits < CFG_DATA_W && $urandom_range(0, 3) == 0)
            v = v | (CFG_DATA_W'($urandom) << bits);
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_seed(o_found, o_seed_x, o_seed_y, o_depth);
    end

    initial begin : result_sink
        int gap_left;
        int since_toggle;
        bit rx_burst;
        gap_left     = 0;
        since_toggle = 0;
        rx_burst     = 1'b0;
        i_out_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (result_hold > 0) begin
                i_out_ready <= 1'b0;
                result_hold = result_hold - 1;
            end else if (gap_left > 0) begin
                i_out_ready <= 1'b0;
                gap_left--;
            end else begin
                i_out_ready <= 1'b1;
                gap_left = rx_burst ? 0 : pick_gap();
            end
            since_toggle++;
            if (since_toggle == 200) begin
                since_toggle = 0;
                rx_burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // all driving tasks start and end just after a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.apply_reg_write(idx, data);
        @(negedge i_clk);
    endtask

    task automatic set_window(input int wv, input int hv, input int ox, input int oy,
                              input int ms);
        write_reg(REG_WIN_WIDTH, with_junk(wv, DIM_W));
        write_reg(REG_WIN_HEIGHT, with_junk(hv, DIM_W));
        write_reg(REG_ORIGIN_X, with_junk(ox, ORG_W));
        write_reg(REG_ORIGIN_Y, with_junk(oy, ORG_W));
        write_reg(REG_MIN_SEED, CFG_DATA_W'(ms));
    endtask

    task automatic send_pixel(input logic b);
        int g;
        g = tx_burst ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid    <= 1'b0;
            i_pixel_valid <= 1'($urandom_range(0, 1));
            repeat (g) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_valid <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_mask_bit(b);
        @(negedge i_clk);
    endtask

    task automatic send_mask(input int count, input int pct);
        for (int i = 0; i < count; i++)
            send_pixel($urandom_range(0, 99) < pct);
    endtask

    // stop offering beats until every seed is back, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_seeds.size() > 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic int pick_density();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 30) return 100;
        if (r < 60) return 50;
        return $urandom_range(80, 97);
    endfunction

    initial begin : stimulus
        int w_reg, h_reg, ox, oy, ms, pix, n_win, pct, part, r;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = REG_WIN_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_pixel_valid = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // solid 3x3 window, deepest pixel is the centre
        set_window(3, 3, 0, 0, 2);
        send_mask(9, 100);
        drain_results();

        // empty mask with a zero threshold reports the origin, here at the far corner
        set_window(1, 1, 4095, 4095, 0);
        send_pixel(1'b0);
        drain_results();

        // threshold at its top, one set pixel is not enough
        write_reg(REG_MIN_SEED, 15'h7fff);
        send_pixel(1'b1);
        drain_results();

        // zero width counts as one, height data carries bits above the register
        write_reg(REG_WIN_WIDTH, 15'h0000);
        write_reg(REG_WIN_HEIGHT, 15'h7f02);
        write_reg(REG_MIN_SEED, 15'd1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        drain_results();

        // geometry rewrite part way through a window restarts it
        set_window(2, 2, 7, 9, 1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        drain_results();
        write_reg(REG_WIN_WIDTH, 15'd2);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        drain_results();

        while (sb.n_beats < TARGET_BEATS || n_settings < MIN_SETTINGS) begin
            r  = $urandom_range(0, 9);
            ox = (r == 0) ? 4095 : (r == 1) ? 0 : $urandom_range(0, 4095);
            r  = $urandom_range(0, 9);
            oy = (r == 0) ? 4095 : (r == 1) ? 0 : $urandom_range(0, 4095);
            n_win = $urandom_range(1, 3);
            if (n_settings == 0) begin
                w_reg = 128;
                h_reg = $urandom_range(1, 2);
                n_win = 1;
            end else if (n_settings == 1) begin
                w_reg = $urandom_range(1, 2);
                h_reg = $urandom_range(128, 255);
                n_win = 1;
            end else if (n_settings == 2) begin
                w_reg = $urandom_range(129, 255);
                h_reg = 1;
                n_win = 1;
            end else if (n_settings == 4 || n_settings == 25) begin
                w_reg = $urandom_range(1, 3);
                h_reg = $urandom_range(1, 3);
                n_win = 4;
            end else if ($urandom_range(0, 9) == 0) begin
                w_reg = $urandom_range(7, 12);
                h_reg = $urandom_range(7, 12);
            end else begin
                w_reg = $urandom_range(1, 6);
                h_reg = $urandom_range(1, 6);
            end
            pix = sb.clamp_dim(DIM_W'(w_reg), MAX_W) * sb.clamp_dim(DIM_W'(h_reg), MAX_H);
            r   = $urandom_range(0, 9);
            ms  = (r == 0) ? 0
                : (r == 1) ? $urandom_range(0, 15'h7fff) : $urandom_range(0, pix + 1);
            set_window(w_reg, h_reg, ox, oy, ms);
            // long hold on the result side while windows keep coming in
            if (n_settings == 4 || n_settings == 25) result_hold = HOLD_CYCLES;
            for (int n = 0; n < n_win; n++) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                pct = pick_density();
                if (pix > 1 && $urandom_range(0, 11) == 0) begin
                    part = $urandom_range(1, pix - 1);
                    send_mask(part, pct);
                    drain_results();
                    write_reg(REG_WIN_WIDTH, with_junk(w_reg, DIM_W));
                    n_aborted++;
                end
                send_mask(pix, pct);
            end
            drain_results();
            n_settings++;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d mask beats: %0d seeds found, %0d windows below threshold",
                 sb.n_beats, sb.n_found, sb.n_not_found);
        $display("over %0d random settings with %0d windows cut short, %0d errors",
                 n_settings, n_aborted, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_seeds.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
